// ===== design/icmp_probe_reply_matcher_defines.svh =====
// Assertion macros for the ICMP probe reply matcher.
// Uses the clk and rst_n names of the including module; empty under SYNTHESIS.
`ifndef ICMP_PROBE_REPLY_MATCHER_DEFINES_SVH
`define ICMP_PROBE_REPLY_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define IPRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define IPRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define IPRM_ASSERT_NOW(label, ante, cons, msg)
`define IPRM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/iprm_pkg.sv =====
// Shared types and constants for the ICMP probe reply matcher.
// No dependencies.
package iprm_pkg;

    typedef enum logic [2:0] {
        ST_MATCH      = 3'd0,
        ST_SHORT      = 3'd1,
        ST_OTHER_TYPE = 3'd2,
        ST_MISMATCH   = 3'd3,
        ST_OVERSIZE   = 3'd4
    } status_t;

    localparam logic [7:0] MSG_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] MSG_TIME_EXCEEDED = 8'd11;

    localparam int unsigned ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_EXPECTED_ID  = 2'd0,
        REG_EXPECTED_SEQ = 2'd1,
        REG_SEND_TIME    = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_idx_t;

    localparam int unsigned SRC_FIRST = 12;
    localparam int unsigned SRC_LAST  = 15;

endpackage

// ===== design/icmp_probe_reply_matcher.sv =====
// ICMP probe reply matcher top level: byte-serial IPv4/ICMP reply parser.
// Depends on iprm_pkg and icmp_probe_reply_matcher_defines.svh.
//
// One packet byte is taken per cycle while not stalled, no gaps required;
// each byte passes the input register and the field-capture logic, and the
// final byte of a packet loads the result register from that register. The
// only back-pressure is from out_stall holding the result register; bytes
// past MAX_PACKET_BYTES are counted as oversize and not examined.
`include "icmp_probe_reply_matcher_defines.svh"

module icmp_probe_reply_matcher
    import iprm_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [31:0]       now_tick,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              matched,
    output logic [2:0]        status,
    output logic [31:0]       source_address,
    output logic [31:0]       round_trip
);

    localparam int unsigned IW = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned CW = IW + 1;
    localparam logic [IW-1:0] MAX_IDX = IW'(MAX_PACKET_BYTES);

    // configuration registers
    logic [15:0] exp_id_reg;
    logic [15:0] exp_seq_reg;
    logic [31:0] send_time_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_id_reg    <= '0;
            exp_seq_reg   <= '0;
            send_time_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_EXPECTED_ID:  exp_id_reg    <= pwdata[15:0];
                REG_EXPECTED_SEQ: exp_seq_reg   <= pwdata[15:0];
                REG_SEND_TIME:    send_time_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_EXPECTED_ID:  prdata = {16'd0, exp_id_reg};
            REG_EXPECTED_SEQ: prdata = {16'd0, exp_seq_reg};
            REG_SEND_TIME:    prdata = send_time_reg;
            default:          prdata = '0;
        endcase
    end

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_data_reg;
    logic        s1_last_reg;
    logic [31:0] s1_now_reg;
    logic        in_take;
    logic        advance;
    logic        proc;

    logic        out_valid_reg, out_valid_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign proc     = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= data_byte;
            s1_last_reg <= last_byte;
            s1_now_reg  <= now_tick;
        end
    end

    // per-packet parse state
    logic [IW-1:0] idx_reg,   idx_next;
    logic [5:0]    hdr_reg,   hdr_next;
    logic [7:0]    type_reg,  type_next;
    logic [5:0]    inner_reg, inner_next;
    logic [15:0]   id_reg,    id_next;
    logic [15:0]   seq_reg,   seq_next;
    logic [31:0]   src_reg,   src_next;
    logic          done_reg,  done_next;

    logic          oversize;
    logic [CW-1:0] ic;
    logic [CW-1:0] hc;
    logic [CW-1:0] base;
    logic          have_base;
    status_t       st;
    logic [31:0]   src_keep;

    always_comb
    begin
        idx_next   = idx_reg;
        hdr_next   = hdr_reg;
        type_next  = type_reg;
        inner_next = inner_reg;
        id_next    = id_reg;
        seq_next   = seq_reg;
        src_next   = src_reg;
        done_next  = done_reg;
        base       = '0;
        have_base  = 1'b0;

        oversize = (idx_reg >= MAX_IDX);
        ic       = CW'(idx_reg);

        if (!oversize)
        begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == '0)
                hdr_next = {s1_data_reg[3:0], 2'b00};
            if (ic >= CW'(SRC_FIRST) && ic <= CW'(SRC_LAST))
                src_next = {src_reg[23:0], s1_data_reg};
        end
        hc = CW'(hdr_next);

        if (!oversize)
        begin
            if (ic == hc)
                type_next = s1_data_reg;
            else if (ic > hc)
            begin
                if (type_reg == MSG_ECHO_REPLY)
                begin
                    base      = hc;
                    have_base = 1'b1;
                end
                else if (type_reg == MSG_TIME_EXCEEDED)
                begin
                    if (ic == hc + CW'(8))
                        inner_next = {s1_data_reg[3:0], 2'b00};
                    base      = hc + CW'(8) + CW'(inner_next);
                    have_base = 1'b1;
                end
            end
            if (have_base)
            begin
                if (ic == base + CW'(4))
                    id_next[7:0] = s1_data_reg;
                else if (ic == base + CW'(5))
                    id_next[15:8] = s1_data_reg;
                else if (ic == base + CW'(6))
                    seq_next[7:0] = s1_data_reg;
                else if (ic == base + CW'(7))
                begin
                    seq_next[15:8] = s1_data_reg;
                    done_next      = 1'b1;
                end
            end
        end

        if (oversize)
            st = ST_OVERSIZE;
        else if (ic + CW'(1) < hc + CW'(8))
            st = ST_SHORT;
        else if (type_next != MSG_ECHO_REPLY && type_next != MSG_TIME_EXCEEDED)
            st = ST_OTHER_TYPE;
        else if (!done_next)
            st = ST_SHORT;
        else if (id_next != exp_id_reg || seq_next != exp_seq_reg)
            st = ST_MISMATCH;
        else
            st = ST_MATCH;

        src_keep = src_next;

        if (s1_last_reg)
        begin
            idx_next   = '0;
            hdr_next   = '0;
            type_next  = '0;
            inner_next = '0;
            id_next    = '0;
            seq_next   = '0;
            src_next   = '0;
            done_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            hdr_reg   <= '0;
            type_reg  <= '0;
            inner_reg <= '0;
            id_reg    <= '0;
            seq_reg   <= '0;
            src_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else if (proc)
        begin
            idx_reg   <= idx_next;
            hdr_reg   <= hdr_next;
            type_reg  <= type_next;
            inner_reg <= inner_next;
            id_reg    <= id_next;
            seq_reg   <= seq_next;
            src_reg   <= src_next;
            done_reg  <= done_next;
        end
    end

    // result register
    logic        matched_reg;
    logic [2:0]  status_reg;
    logic [31:0] src_out_reg;
    logic [31:0] rtt_reg;
    logic        result_load;

    assign result_load = proc && s1_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            matched_reg <= (st == ST_MATCH);
            status_reg  <= st;
            src_out_reg <= (st == ST_MATCH) ? src_keep : 32'd0;
            rtt_reg     <= (st == ST_MATCH) ? (s1_now_reg - send_time_reg) : 32'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign matched        = matched_reg;
    assign status         = status_reg;
    assign source_address = src_out_reg;
    assign round_trip     = rtt_reg;

    `IPRM_ASSERT_NOW(a_idx_bound, 1'b1, idx_reg <= MAX_IDX, "byte count beyond limit")
    `IPRM_ASSERT_NEXT(a_clear_after_last, result_load, idx_reg == '0 && !done_reg,
        "packet state not cleared after last byte")
    `IPRM_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_reg && out_valid_reg,
        "input stalled with no pending transaction")
    `IPRM_ASSERT_NOW(a_nomatch_zero, out_valid && !matched,
        source_address == 32'd0 && round_trip == 32'd0 && status != ST_MATCH,
        "unmatched result carries data")

endmodule

// ===== bench/tb_icmp_probe_reply_matcher.sv =====
// Self-checking bench for icmp_probe_reply_matcher: random and directed IPv4/ICMP packets in
// byte transactions, with results checked by a scoreboard that keeps its own parser.
// Depends on iprm_pkg and the icmp_probe_reply_matcher RTL.
module tb_icmp_probe_reply_matcher;
    import iprm_pkg::*;

    localparam int unsigned MAX_BYTES   = 1024;
    localparam int unsigned CYCLE_LIMIT = 800000;

    typedef struct {
        logic        matched;
        status_t     status;
        logic [31:0] source_address;
        logic [31:0] round_trip;
    } reply_t;

    class reply_scoreboard;
        bit [15:0] want_id;
        bit [15:0] want_seq;
        bit [31:0] sent_at;
        bit [10:0] byte_index;
        bit [5:0]  outer_len;
        bit [7:0]  msg_type;
        bit [5:0]  inner_len;
        bit [15:0] id_seen;
        bit [15:0] seq_seen;
        bit [31:0] src_seen;
        bit        fields_done;
        reply_t    replies_due[$];
        int unsigned fails;
        int unsigned replies_seen;

        function void set_register(reg_idx_t idx, bit [31:0] value);
            case (idx)
                REG_EXPECTED_ID:  want_id  = value[15:0];
                REG_EXPECTED_SEQ: want_seq = value[15:0];
                REG_SEND_TIME:    sent_at  = value;
                default: ;
            endcase
        endfunction

        function void clear_packet();
            byte_index  = '0;
            outer_len   = '0;
            msg_type    = '0;
            inner_len   = '0;
            id_seen     = '0;
            seq_seen    = '0;
            src_seen    = '0;
            fields_done = 1'b0;
        endfunction

        function void capture(int unsigned i, bit [7:0] d);
            int unsigned base;
            if (i == 0)
                outer_len = {d[3:0], 2'b00};
            if (i >= SRC_FIRST && i <= SRC_LAST)
                src_seen = {src_seen[23:0], d};
            if (i == outer_len)
            begin
                msg_type = d;
                return;
            end
            if (i < outer_len)
                return;
            if (msg_type == MSG_ECHO_REPLY)
                base = outer_len;
            else if (msg_type == MSG_TIME_EXCEEDED)
            begin
                if (i == outer_len + 8)
                    inner_len = {d[3:0], 2'b00};
                base = outer_len + 8 + inner_len;
            end
            else
                return;
            if (i == base + 4)
                id_seen[7:0] = d;
            else if (i == base + 5)
                id_seen[15:8] = d;
            else if (i == base + 6)
                seq_seen[7:0] = d;
            else if (i == base + 7)
            begin
                seq_seen[15:8] = d;
                fields_done    = 1'b1;
            end
        endfunction

        function void note_byte(bit [7:0] d, bit last, bit [31:0] now);
            int unsigned i;
            status_t     st;
            reply_t      r;
            i = byte_index;
            if (i < MAX_BYTES)
            begin
                capture(i, d);
                byte_index = 11'(i + 1);
            end
            if (!last)
                return;
            if (i >= MAX_BYTES)
                st = ST_OVERSIZE;
            else if (i + 1 < outer_len + 8)
                st = ST_SHORT;
            else if (msg_type != MSG_ECHO_REPLY && msg_type != MSG_TIME_EXCEEDED)
                st = ST_OTHER_TYPE;
            else if (!fields_done)
                st = ST_SHORT;
            else if (id_seen != want_id || seq_seen != want_seq)
                st = ST_MISMATCH;
            else
                st = ST_MATCH;
            r.matched        = (st == ST_MATCH);
            r.status         = st;
            r.source_address = (st == ST_MATCH) ? src_seen : 32'd0;
            r.round_trip     = (st == ST_MATCH) ? now - sent_at : 32'd0;
            replies_due.push_back(r);
            clear_packet();
        endfunction

        function void report(string what);
            fails++;
            if (fails <= 10)
                $display("%s", what);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (replies_due.size() == 0)
            begin
                report($sformatf("unexpected result: matched %0b status %0d source %h rtt %h",
                                 got.matched, got.status, got.source_address, got.round_trip));
                return;
            end
            want = replies_due.pop_front();
            replies_seen++;
            if (got.matched !== want.matched || got.status !== want.status
                || got.source_address !== want.source_address
                || got.round_trip !== want.round_trip)
                report($sformatf({"result %0d: expected matched %0b status %0d source %h rtt %h,",
                                  " got matched %0b status %0d source %h rtt %h"},
                                 replies_seen, want.matched, want.status, want.source_address,
                                 want.round_trip, got.matched, got.status, got.source_address,
                                 got.round_trip));
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [31:0]       now_tick;
    logic              out_valid;
    logic              out_stall;
    logic              matched;
    logic [2:0]        status;
    logic [31:0]       source_address;
    logic [31:0]       round_trip;

    reply_scoreboard sb = new();
    bit [7:0]        pkt[$];
    bit              sender_gaps;
    bit              receiver_stalls;
    int unsigned     bytes_sent;
    int unsigned     cycle_count;

    icmp_probe_reply_matcher #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .now_tick       (now_tick),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .matched        (matched),
        .status         (status),
        .source_address (source_address),
        .round_trip     (round_trip)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("icmp_probe_reply_matcher regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_byte(data_byte, last_byte, now_tick);
    end

    always @(posedge clk)
    begin
        reply_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.matched        = matched;
            got.status         = status_t'(status);
            got.source_address = source_address;
            got.round_trip     = round_trip;
            sb.check_reply(got);
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(reg_idx_t idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // mode 0: all zero, mode 1: all ones, otherwise random
    task automatic configure(int unsigned mode);
        bit [31:0] v_id;
        bit [31:0] v_seq;
        bit [31:0] v_time;
        v_id   = (mode == 0) ? 32'd0 : (mode == 1) ? 32'h0000_ffff : {16'd0, 16'($urandom)};
        v_seq  = (mode == 0) ? 32'd0 : (mode == 1) ? 32'h0000_ffff : {16'd0, 16'($urandom)};
        v_time = (mode == 0) ? 32'd0 : (mode == 1) ? 32'hffff_ffff : $urandom;
        write_reg(REG_EXPECTED_ID, v_id);
        write_reg(REG_EXPECTED_SEQ, v_seq);
        write_reg(REG_SEND_TIME, v_time);
    endtask

    function automatic bit [31:0] pick_tick();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [3:0] pick_nibble();
        return ($urandom_range(0, 9) < 6) ? 4'd5 : 4'($urandom);
    endfunction

    task automatic send_byte(bit [7:0] d, bit last);
        if (sender_gaps && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= last;
        now_tick  <= pick_tick();
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[k])
            send_byte(pkt[k], k == pkt.size() - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Well-formed echo reply or time-exceeded message, then tail bytes of padding.
    function automatic void build_reply(bit exceeded, bit hit, bit [3:0] nib, bit [3:0] inib,
                                        int unsigned tail);
        int unsigned h;
        int unsigned base;
        bit          coin;
        bit [15:0]   id;
        bit [15:0]   seq;
        if (exceeded && nib == 0)
            nib = 4'd5;
        h    = nib * 4;
        base = exceeded ? h + 8 + inib * 4 : h;
        coin = $urandom_range(0, 1);
        id   = (hit || coin) ? sb.want_id : 16'($urandom);
        seq  = (hit || !coin) ? sb.want_seq : 16'($urandom);
        pkt.delete();
        repeat (base + 8 + tail) pkt.push_back(8'($urandom));
        pkt[0] = {4'($urandom), nib};
        pkt[h] = exceeded ? MSG_TIME_EXCEEDED : MSG_ECHO_REPLY;
        if (exceeded)
            pkt[h + 8] = {4'($urandom), inib};
        pkt[base + 4] = id[7:0];
        pkt[base + 5] = id[15:8];
        pkt[base + 6] = seq[7:0];
        pkt[base + 7] = seq[15:8];
    endfunction

    function automatic void set_other_type();
        bit [7:0] t;
        do t = 8'($urandom); while (t == MSG_ECHO_REPLY || t == MSG_TIME_EXCEEDED);
        pkt[pkt[0][3:0] * 4] = t;
    endfunction

    function automatic void cut_to(int unsigned len);
        while (pkt.size() > len)
            void'(pkt.pop_back());
    endfunction

    task automatic random_packet();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            build_reply(1'b0, $urandom_range(0, 9) < 7, pick_nibble(), 4'd0,
                        $urandom_range(0, 10));
        else if (pick < 75)
            build_reply(1'b1, $urandom_range(0, 9) < 7, pick_nibble(), pick_nibble(),
                        $urandom_range(0, 10));
        else if (pick < 83)
        begin
            build_reply($urandom_range(0, 1), 1'b1, pick_nibble(), pick_nibble(),
                        $urandom_range(0, 6));
            set_other_type();
        end
        else if (pick < 92)
        begin
            build_reply($urandom_range(0, 1), 1'b1, pick_nibble(), pick_nibble(), 0);
            cut_to($urandom_range(1, pkt.size()));
        end
        else
        begin
            pkt.delete();
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
        end
        send_packet();
    endtask

    initial
    begin
        int unsigned rounds;
        int unsigned target;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        data_byte       = '0;
        last_byte       = 1'b0;
        now_tick        = '0;
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        bytes_sent      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: boundary lengths, both message types, odd header lengths
        configure(1);
        build_reply(1'b0, 1'b1, 4'd5, 4'd0, 0);
        send_packet();
        build_reply(1'b1, 1'b1, 4'd5, 4'd5, 0);
        send_packet();
        build_reply(1'b0, 1'b0, 4'd5, 4'd0, 2);
        send_packet();
        build_reply(1'b0, 1'b1, 4'd5, 4'd0, 1);
        set_other_type();
        send_packet();
        build_reply(1'b0, 1'b1, 4'd5, 4'd0, 0);
        cut_to(27);
        send_packet();
        build_reply(1'b1, 1'b1, 4'd5, 4'd5, 0);
        cut_to(55);
        send_packet();
        build_reply(1'b0, 1'b1, 4'd0, 4'd0, 0);
        send_packet();
        build_reply(1'b1, 1'b1, 4'd15, 4'd15, 0);
        send_packet();
        build_reply(1'b0, 1'b1, 4'd1, 4'd0, 3);
        send_packet();
        pkt.delete();
        pkt.push_back(8'hff);
        send_packet();
        wait_idle();
        configure(0);
        build_reply(1'b0, 1'b1, 4'd5, 4'd0, 0);
        send_packet();
        build_reply(1'b1, 1'b0, 4'd6, 4'd7, 0);
        send_packet();
        wait_idle();

        rounds = 0;
        while (bytes_sent < 1000)
        begin
            rounds++;
            sender_gaps     = (rounds % 4 != 3);
            receiver_stalls = (rounds % 3 != 2);
            configure(rounds % 5);
            if (rounds == 1)
            begin
                build_reply(1'b0, 1'b1, 4'd5, 4'd0, 0);
                target = MAX_BYTES + 1 + $urandom_range(0, 5);
                while (pkt.size() < target)
                    pkt.push_back(8'($urandom));
                send_packet();
                build_reply(1'b1, 1'b1, 4'd5, 4'd5, 0);
                while (pkt.size() < MAX_BYTES)
                    pkt.push_back(8'($urandom));
                send_packet();
            end
            repeat (12) random_packet();
            wait_idle();
        end

        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        configure(2);
        repeat (10) random_packet();
        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.fails == 0 && sb.replies_due.size() == 0)
            $display("icmp_probe_reply_matcher regression: pass");
        else
            $display("icmp_probe_reply_matcher regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+design
design/iprm_pkg.sv
design/icmp_probe_reply_matcher.sv
bench/tb_icmp_probe_reply_matcher.sv
